@@ sv/bslc_pkg.sv @@
// Package: types, character codes and widths shared by the source line classifier.
`timescale 1ns / 1ps
`default_nettype none
package bslc_pkg;

	// Widths of the payload fields and the default line counter width.
	localparam int CHAR_W          = 8;
	localparam int CLASS_W         = 2;
	localparam int LINE_NUMBER_W   = 32;
	localparam int LINE_COUNT_BITS = 32;

	// Character codes the scanner reacts to.
	localparam logic [CHAR_W-1:0] CH_BANG       = 8'h21;
	localparam logic [CHAR_W-1:0] CH_DOLLAR     = 8'h24;
	localparam logic [CHAR_W-1:0] CH_PERCENT    = 8'h25;
	localparam logic [CHAR_W-1:0] CH_QUOTE      = 8'h27;
	localparam logic [CHAR_W-1:0] CH_LPAREN     = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN     = 8'h29;
	localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
	localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_DIGIT_0    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_DIGIT_9    = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;

	// Lexical scan modes, one-hot.
	typedef enum logic [9:0] {
		MODE_START   = 10'b00_0000_0001,
		MODE_NAME    = 10'b00_0000_0010,
		MODE_NUMBER  = 10'b00_0000_0100,
		MODE_SPACE   = 10'b00_0000_1000,
		MODE_QUOTED  = 10'b00_0001_0000,
		MODE_TRAIL   = 10'b00_0010_0000,
		MODE_EMBED   = 10'b00_0100_0000,
		MODE_PERCENT = 10'b00_1000_0000,
		MODE_QCLOSE  = 10'b01_0000_0000,
		MODE_ECLOSE  = 10'b10_0000_0000
	} mode_t;

	// Scanner state held between bytes.
	typedef struct packed {
		mode_t mode;
		logic  code_seen;
		logic  comment_seen;
	} scan_state_t;

	// Outcome of scanning one byte: next state and an optional finished line.
	typedef struct packed {
		scan_state_t              next;
		logic                     emit;
		logic [CLASS_W-1:0]       line_class;
	} scan_res_t;

endpackage
`default_nettype wire

@@ sv/bslc_in_if.sv @@
// Interface: source byte channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface bslc_in_if;
	logic                        valid;
	logic                        ready;
	logic [bslc_pkg::CHAR_W-1:0] char_code;
	logic                        end_of_file;

	modport source (output valid, output char_code, output end_of_file, input ready);
	modport sink   (input valid, input char_code, input end_of_file, output ready);
endinterface
`default_nettype wire

@@ sv/bslc_out_if.sv @@
// Interface: line result channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface bslc_out_if;
	logic                               valid;
	logic                               ready;
	logic [bslc_pkg::CLASS_W-1:0]       line_class;
	logic [bslc_pkg::LINE_NUMBER_W-1:0] line_number;

	modport source (output valid, output line_class, output line_number, input ready);
	modport sink   (input valid, input line_class, input line_number, output ready);
endinterface
`default_nettype wire

@@ sv/bslc_scan.sv @@
// Module: next-state logic of the lexical scanner for one source byte.
`timescale 1ns / 1ps
`default_nettype none
module bslc_scan (
	input  wire logic [bslc_pkg::CHAR_W-1:0] char_code,
	input  wire bslc_pkg::scan_state_t       cur,
	output bslc_pkg::scan_res_t              res
);

	function automatic logic is_alpha(logic [bslc_pkg::CHAR_W-1:0] c);
		return c inside {[bslc_pkg::CH_UPPER_A:bslc_pkg::CH_UPPER_Z],
			[bslc_pkg::CH_LOWER_A:bslc_pkg::CH_LOWER_Z]};
	endfunction

	function automatic logic is_digit(logic [bslc_pkg::CHAR_W-1:0] c);
		return c inside {[bslc_pkg::CH_DIGIT_0:bslc_pkg::CH_DIGIT_9]};
	endfunction

	function automatic logic is_space(logic [bslc_pkg::CHAR_W-1:0] c);
		return c inside {bslc_pkg::CH_SPACE, [bslc_pkg::CH_TAB:bslc_pkg::CH_CR]};
	endfunction

	function automatic logic is_name_start(logic [bslc_pkg::CHAR_W-1:0] c);
		return is_alpha(c) || (c == bslc_pkg::CH_UNDERSCORE) || (c == bslc_pkg::CH_DOLLAR);
	endfunction

	// Result that keeps the given flags and mode, with no finished line.
	function automatic bslc_pkg::scan_res_t hold(bslc_pkg::mode_t m, logic code, logic comm);
		bslc_pkg::scan_res_t r;
		r.next.mode         = m;
		r.next.code_seen    = code;
		r.next.comment_seen = comm;
		r.emit              = 1'b0;
		r.line_class        = {comm, code};
		return r;
	endfunction

	// Result that closes the current line and clears both flags.
	function automatic bslc_pkg::scan_res_t finish(bslc_pkg::mode_t m, logic code, logic comm);
		bslc_pkg::scan_res_t r;
		r.next.mode         = m;
		r.next.code_seen    = 1'b0;
		r.next.comment_seen = 1'b0;
		r.emit              = 1'b1;
		r.line_class        = {comm, code};
		return r;
	endfunction

	// Classification of a byte from the start mode.
	function automatic bslc_pkg::scan_res_t from_start(logic [bslc_pkg::CHAR_W-1:0] c,
			logic code, logic comm);
		bslc_pkg::scan_res_t r;
		if (is_name_start(c)) begin
			r = hold(bslc_pkg::MODE_NAME, 1'b1, comm);
		end else if (is_digit(c)) begin
			r = hold(bslc_pkg::MODE_NUMBER, 1'b1, comm);
		end else if (is_space(c)) begin
			if (c == bslc_pkg::CH_NEWLINE) begin
				r = finish(bslc_pkg::MODE_SPACE, code, comm);
			end else begin
				r = hold(bslc_pkg::MODE_SPACE, code, comm);
			end
		end else if (c == bslc_pkg::CH_QUOTE) begin
			r = hold(bslc_pkg::MODE_QUOTED, 1'b1, comm);
		end else if (c == bslc_pkg::CH_BANG) begin
			r = hold(bslc_pkg::MODE_TRAIL, code, 1'b1);
		end else if (c == bslc_pkg::CH_PERCENT) begin
			r = hold(bslc_pkg::MODE_PERCENT, code, comm);
		end else begin
			r = hold(bslc_pkg::MODE_START, 1'b1, comm);
		end
		return r;
	endfunction

	// Handling of a byte inside an embedded comment.
	function automatic bslc_pkg::scan_res_t from_embed(logic [bslc_pkg::CHAR_W-1:0] c,
			logic code, logic comm);
		bslc_pkg::scan_res_t r;
		if (c == bslc_pkg::CH_RPAREN) begin
			r = hold(bslc_pkg::MODE_ECLOSE, code, 1'b1);
		end else if (c == bslc_pkg::CH_NEWLINE) begin
			r = finish(bslc_pkg::MODE_EMBED, code, comm);
		end else begin
			r = hold(bslc_pkg::MODE_EMBED, code, 1'b1);
		end
		return r;
	endfunction

	// A byte that ends a token is handed on to the mode that follows, in the same cycle.
	always_comb begin
		case (cur.mode)
			bslc_pkg::MODE_START: begin
				res = from_start(char_code, cur.code_seen, cur.comment_seen);
			end
			bslc_pkg::MODE_NAME: begin
				if (is_name_start(char_code) || is_digit(char_code)) begin
					res = hold(bslc_pkg::MODE_NAME, 1'b1, cur.comment_seen);
				end else begin
					res = from_start(char_code, cur.code_seen, cur.comment_seen);
				end
			end
			bslc_pkg::MODE_NUMBER: begin
				if (is_digit(char_code)) begin
					res = hold(bslc_pkg::MODE_NUMBER, 1'b1, cur.comment_seen);
				end else begin
					res = from_start(char_code, cur.code_seen, cur.comment_seen);
				end
			end
			bslc_pkg::MODE_SPACE: begin
				if (char_code == bslc_pkg::CH_NEWLINE) begin
					res = finish(bslc_pkg::MODE_SPACE, cur.code_seen, cur.comment_seen);
				end else if (is_space(char_code)) begin
					res = hold(bslc_pkg::MODE_SPACE, cur.code_seen, cur.comment_seen);
				end else begin
					res = from_start(char_code, cur.code_seen, cur.comment_seen);
				end
			end
			bslc_pkg::MODE_QUOTED: begin
				if (char_code == bslc_pkg::CH_QUOTE) begin
					res = hold(bslc_pkg::MODE_QCLOSE, 1'b1, cur.comment_seen);
				end else if (char_code == bslc_pkg::CH_NEWLINE) begin
					res = finish(bslc_pkg::MODE_QUOTED, cur.code_seen, cur.comment_seen);
				end else begin
					res = hold(bslc_pkg::MODE_QUOTED, 1'b1, cur.comment_seen);
				end
			end
			bslc_pkg::MODE_QCLOSE: begin
				// A doubled quote stands for one quote and the literal goes on.
				if (char_code == bslc_pkg::CH_QUOTE) begin
					res = hold(bslc_pkg::MODE_QUOTED, 1'b1, cur.comment_seen);
				end else begin
					res = from_start(char_code, cur.code_seen, cur.comment_seen);
				end
			end
			bslc_pkg::MODE_TRAIL: begin
				if (char_code == bslc_pkg::CH_NEWLINE) begin
					res = finish(bslc_pkg::MODE_START, cur.code_seen, cur.comment_seen);
				end else begin
					res = hold(bslc_pkg::MODE_TRAIL, cur.code_seen, 1'b1);
				end
			end
			bslc_pkg::MODE_EMBED: begin
				res = from_embed(char_code, cur.code_seen, cur.comment_seen);
			end
			bslc_pkg::MODE_ECLOSE: begin
				if (char_code == bslc_pkg::CH_PERCENT) begin
					res = hold(bslc_pkg::MODE_START, cur.code_seen, 1'b1);
				end else begin
					res = from_embed(char_code, cur.code_seen, cur.comment_seen);
				end
			end
			bslc_pkg::MODE_PERCENT: begin
				// After a percent, an open paren opens a comment and a name or digit begins a name.
				if (char_code == bslc_pkg::CH_LPAREN) begin
					res = hold(bslc_pkg::MODE_EMBED, cur.code_seen, 1'b1);
				end else if (is_name_start(char_code) || is_digit(char_code)) begin
					res = hold(bslc_pkg::MODE_NAME, 1'b1, cur.comment_seen);
				end else begin
					res = from_start(char_code, 1'b1, cur.comment_seen);
				end
			end
			default: begin
				res = from_start(char_code, cur.code_seen, cur.comment_seen);
			end
		endcase
	end

endmodule
`default_nettype wire

@@ sv/bslc_line_count.sv @@
// Module: saturating count of finished lines and the reported line number.
`timescale 1ns / 1ps
`default_nettype none
module bslc_line_count #(
	parameter int LINE_COUNT_BITS = bslc_pkg::LINE_COUNT_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               inc,
	input  wire logic                               clr,
	output logic [bslc_pkg::LINE_NUMBER_W-1:0]      line_number
);

	localparam int EXT_W = (LINE_COUNT_BITS > bslc_pkg::LINE_NUMBER_W) ?
		LINE_COUNT_BITS : bslc_pkg::LINE_NUMBER_W;

	logic [LINE_COUNT_BITS-1:0] count_q;
	logic [LINE_COUNT_BITS-1:0] count_next;
	logic [EXT_W-1:0]           count_ext;

	// The count stops at its maximum.
	assign count_next = (&count_q) ? count_q : count_q + LINE_COUNT_BITS'(1);

	// The number of the line being finished, clipped to the field width.
	assign count_ext   = EXT_W'(count_next);
	assign line_number = (count_ext > EXT_W'({bslc_pkg::LINE_NUMBER_W{1'b1}})) ?
		{bslc_pkg::LINE_NUMBER_W{1'b1}} : count_ext[bslc_pkg::LINE_NUMBER_W-1:0];

	// Counter register; the end marker clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clr) begin
			count_q <= '0;
		end else if (inc) begin
			count_q <= count_next;
		end
	end

endmodule
`default_nettype wire

@@ sv/bliss_source_line_classifier.sv @@
// A byte accepted into the input register is scanned from there, and the line that it finishes
// is written into the result register when the scan advances.
// Throughput: one byte per cycle while no result waits, set by the scanner state update.
// A waiting result stalls scanning; the input register still holds up to one byte meanwhile.
// Reset: arst_n clears scanner mode, flags, line count and both valid flags at once.
`timescale 1ns / 1ps
`default_nettype none
module bliss_source_line_classifier #(
	parameter int LINE_COUNT_BITS = bslc_pkg::LINE_COUNT_BITS
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bslc_in_if.sink   bytes,
	bslc_out_if.source lines
);

	logic                              valid_s1;
	logic [bslc_pkg::CHAR_W-1:0]       char_s1;
	logic                              eof_s1;
	bslc_pkg::scan_state_t             state_q;
	bslc_pkg::scan_res_t               res;
	logic                              advance;
	logic                              emit;
	logic [bslc_pkg::LINE_NUMBER_W-1:0] number_next;
	logic                              out_valid_q;
	logic [bslc_pkg::CLASS_W-1:0]      class_q;
	logic [bslc_pkg::LINE_NUMBER_W-1:0] number_q;

	// The held byte is scanned when the result register can take a line.
	assign advance     = valid_s1 && (!out_valid_q || lines.ready);
	assign bytes.ready = !valid_s1 || advance;
	assign emit        = advance && !eof_s1 && res.emit;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			char_s1 <= bytes.char_code;
			eof_s1  <= bytes.end_of_file;
		end
	end

	bslc_scan u_scan (
		.char_code (char_s1),
		.cur       (state_q),
		.res       (res)
	);

	bslc_line_count #(
		.LINE_COUNT_BITS (LINE_COUNT_BITS)
	) u_line_count (
		.clk         (clk),
		.arst_n      (arst_n),
		.inc         (emit),
		.clr         (advance && eof_s1),
		.line_number (number_next)
	);

	// Scanner state; the end marker returns it to the start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode         <= bslc_pkg::MODE_START;
			state_q.code_seen    <= 1'b0;
			state_q.comment_seen <= 1'b0;
		end else if (advance) begin
			if (eof_s1) begin
				state_q.mode         <= bslc_pkg::MODE_START;
				state_q.code_seen    <= 1'b0;
				state_q.comment_seen <= 1'b0;
			end else begin
				state_q <= res.next;
			end
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (lines.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			class_q  <= res.line_class;
			number_q <= number_next;
		end
	end

	assign lines.valid       = out_valid_q;
	assign lines.line_class  = class_q;
	assign lines.line_number = number_q;

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the source line classifier: directed table, random BLISS text.
`timescale 1ns / 1ps
module tb_top;
	import bslc_pkg::*;

	// Line classes as reported on the result channel.
	localparam logic [CLASS_W-1:0] CLASS_BLANK   = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_CODE    = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_COMMENT = 2'd2;
	localparam logic [CLASS_W-1:0] CLASS_MIXED   = 2'd3;

	// Further characters used by the stimulus.
	localparam logic [CHAR_W-1:0] CH_VT      = 8'h0B;
	localparam logic [CHAR_W-1:0] CH_FF      = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UPPER_Q = 8'h51;
	localparam logic [CHAR_W-1:0] CH_HIGH    = 8'h80;
	localparam logic [CHAR_W-1:0] CH_MAX     = 8'hFF;
	localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
	localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7E;

	localparam int CLK_HALF     = 2;
	localparam int RESET_CYCLES = 10;
	localparam int IDLE_PCT     = 23;
	localparam int RANDOM_N     = 650;
	localparam int DRAIN_CYCLES = 8;
	localparam int TIMEOUT_NS   = 400000;
	localparam int MAX_PRINTS   = 50;
	// Receiver hold-off and calm stretch, in receiver cycles.
	localparam int HOLD_FROM    = 200;
	localparam int HOLD_LEN     = 150;
	localparam int RX_CALM_FROM = 600;
	localparam int RX_CALM_LEN  = 200;
	// Sender calm stretch, in word indexes.
	localparam int TX_CALM_FROM = 400;
	localparam int TX_CALM_TO   = 520;

	// One source word, with an optional typed-in expectation.
	typedef struct packed {
		logic [CHAR_W-1:0]        ch;
		logic                     eof;
		logic                     typed;
		logic [CLASS_W-1:0]       cls;
		logic [LINE_NUMBER_W-1:0] num;
	} src_word_t;

	typedef struct packed {
		logic [CLASS_W-1:0]       cls;
		logic [LINE_NUMBER_W-1:0] num;
	} line_t;

	localparam int DIRECTED_N = 25;
	localparam src_word_t DIRECTED_WORDS [DIRECTED_N] = '{
		'{CH_NEWLINE, 1'b0, 1'b1, CLASS_BLANK,   32'd1},
		'{CH_LOWER_Z, 1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_NEWLINE, 1'b0, 1'b1, CLASS_CODE,    32'd2},
		'{CH_BANG,    1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_MAX,     1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_NEWLINE, 1'b0, 1'b1, CLASS_COMMENT, 32'd3},
		'{CH_PERCENT, 1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_LPAREN,  1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_RPAREN,  1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_LOWER_X, 1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_RPAREN,  1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_PERCENT, 1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_NEWLINE, 1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_PERCENT, 1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_UPPER_Q, 1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_NEWLINE, 1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_QUOTE,   1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_QUOTE,   1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_QUOTE,   1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_NEWLINE, 1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_QUOTE,   1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_HIGH,    1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_BANG,    1'b0, 1'b0, CLASS_BLANK,   32'd0},
		'{CH_NEWLINE, 1'b0, 1'b1, CLASS_MIXED,   32'd7},
		'{CH_NUL,     1'b1, 1'b0, CLASS_BLANK,   32'd0}
	};

	logic clk = 1'b0;
	logic arst_n;

	bslc_in_if  byte_chan ();
	bslc_out_if line_chan ();

	bliss_source_line_classifier DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_chan),
		.lines  (line_chan)
	);

	// Clock generation.
	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	src_word_t src_words [$];
	line_t     pending_lines [$];
	int unsigned accepted_n;
	int unsigned mismatch_n;

	// Scanner state mirrored by the line predictor.
	mode_t                      scan_mode_q;
	logic                       code_seen_q;
	logic                       comment_seen_q;
	logic [LINE_COUNT_BITS-1:0] lines_done_q;

	function automatic bit is_letter(logic [CHAR_W-1:0] c);
		return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
	endfunction

	function automatic bit is_digit(logic [CHAR_W-1:0] c);
		return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
	endfunction

	function automatic bit is_blank(logic [CHAR_W-1:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_name_start(logic [CHAR_W-1:0] c);
		return is_letter(c) || c == CH_UNDERSCORE || c == CH_DOLLAR;
	endfunction

	function automatic void reset_scanner();
		scan_mode_q    = MODE_START;
		code_seen_q    = 1'b0;
		comment_seen_q = 1'b0;
		lines_done_q   = '0;
	endfunction

	// Completes the current line: bumps the saturating count and clears both flags.
	function automatic line_t close_line();
		line_t r;
		if (lines_done_q != '1)
			lines_done_q = lines_done_q + 1'b1;
		r.cls = {comment_seen_q, code_seen_q};
		if (LINE_COUNT_BITS > LINE_NUMBER_W && lines_done_q > {LINE_NUMBER_W{1'b1}})
			r.num = '1;
		else
			r.num = LINE_NUMBER_W'(lines_done_q);
		code_seen_q    = 1'b0;
		comment_seen_q = 1'b0;
		return r;
	endfunction

	// Scans one byte; a byte that ends a token is taken again in the mode that follows.
	task automatic classify_byte(input logic [CHAR_W-1:0] c, output bit hit, output line_t res);
		bit again;
		hit = 1'b0;
		res = '0;
		do begin
			again = 1'b0;
			case (scan_mode_q)
				MODE_START: begin
					if (is_name_start(c)) begin
						scan_mode_q = MODE_NAME;
						code_seen_q = 1'b1;
					end else if (is_digit(c)) begin
						scan_mode_q = MODE_NUMBER;
						code_seen_q = 1'b1;
					end else if (is_blank(c)) begin
						if (c == CH_NEWLINE) begin
							res = close_line();
							hit = 1'b1;
						end
						scan_mode_q = MODE_SPACE;
					end else if (c == CH_QUOTE) begin
						scan_mode_q = MODE_QUOTED;
						code_seen_q = 1'b1;
					end else if (c == CH_BANG) begin
						scan_mode_q    = MODE_TRAIL;
						comment_seen_q = 1'b1;
					end else if (c == CH_PERCENT) begin
						scan_mode_q = MODE_PERCENT;
					end else begin
						code_seen_q = 1'b1;
					end
				end
				MODE_NAME: begin
					if (is_name_start(c) || is_digit(c)) begin
						code_seen_q = 1'b1;
					end else begin
						scan_mode_q = MODE_START;
						again = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit(c)) begin
						code_seen_q = 1'b1;
					end else begin
						scan_mode_q = MODE_START;
						again = 1'b1;
					end
				end
				MODE_SPACE: begin
					if (is_blank(c)) begin
						if (c == CH_NEWLINE) begin
							res = close_line();
							hit = 1'b1;
						end
					end else begin
						scan_mode_q = MODE_START;
						again = 1'b1;
					end
				end
				MODE_QUOTED: begin
					if (c == CH_QUOTE) begin
						code_seen_q = 1'b1;
						scan_mode_q = MODE_QCLOSE;
					end else if (c == CH_NEWLINE) begin
						res = close_line();
						hit = 1'b1;
					end else begin
						code_seen_q = 1'b1;
					end
				end
				MODE_QCLOSE: begin
					// A doubled quote keeps the literal open.
					if (c == CH_QUOTE) begin
						code_seen_q = 1'b1;
						scan_mode_q = MODE_QUOTED;
					end else begin
						scan_mode_q = MODE_START;
						again = 1'b1;
					end
				end
				MODE_TRAIL: begin
					if (c == CH_NEWLINE) begin
						res = close_line();
						hit = 1'b1;
						scan_mode_q = MODE_START;
					end else begin
						comment_seen_q = 1'b1;
					end
				end
				MODE_EMBED: begin
					if (c == CH_RPAREN) begin
						comment_seen_q = 1'b1;
						scan_mode_q    = MODE_ECLOSE;
					end else if (c == CH_NEWLINE) begin
						res = close_line();
						hit = 1'b1;
					end else begin
						comment_seen_q = 1'b1;
					end
				end
				MODE_ECLOSE: begin
					if (c == CH_PERCENT) begin
						comment_seen_q = 1'b1;
						scan_mode_q    = MODE_START;
					end else begin
						scan_mode_q = MODE_EMBED;
						again = 1'b1;
					end
				end
				MODE_PERCENT: begin
					// A percent sign without an opening bracket starts a name.
					if (c == CH_LPAREN) begin
						comment_seen_q = 1'b1;
						scan_mode_q    = MODE_EMBED;
					end else begin
						code_seen_q = 1'b1;
						scan_mode_q = MODE_NAME;
						again = 1'b1;
					end
				end
				default: begin
					scan_mode_q = MODE_START;
					again = 1'b1;
				end
			endcase
		end while (again);
	endtask

	task automatic report_mismatch(input string msg);
		if (mismatch_n < MAX_PRINTS)
			$display("%0t ns: mismatch: %s", $time, msg);
		mismatch_n++;
	endtask

	task automatic push_char(input logic [CHAR_W-1:0] c);
		src_word_t w;
		w = '0;
		w.ch = c;
		src_words.push_back(w);
	endtask

	function automatic logic [CHAR_W-1:0] pick_letter();
		if ($urandom_range(0, 1))
			return CH_UPPER_A + CHAR_W'($urandom_range(0, 25));
		return CH_LOWER_A + CHAR_W'($urandom_range(0, 25));
	endfunction

	function automatic logic [CHAR_W-1:0] pick_digit();
		return CH_DIGIT_0 + CHAR_W'($urandom_range(0, 9));
	endfunction

	function automatic logic [CHAR_W-1:0] pick_blank();
		case ($urandom_range(0, 4))
			0: return CH_TAB;
			1: return CH_VT;
			2: return CH_FF;
			3: return CH_CR;
			default: return CH_SPACE;
		endcase
	endfunction

	// Appends one lexical fragment: mostly well-formed tokens, some noise and broken ones.
	task automatic add_fragment();
		int k;
		int n;
		logic [CHAR_W-1:0] c;
		src_word_t w;
		k = $urandom_range(0, 99);
		if (k < 15) begin
			case ($urandom_range(0, 3))
				0: push_char(CH_UNDERSCORE);
				1: push_char(CH_DOLLAR);
				default: push_char(pick_letter());
			endcase
			n = $urandom_range(0, 5);
			repeat (n) begin
				case ($urandom_range(0, 3))
					0: push_char(pick_digit());
					1: push_char($urandom_range(0, 1) ? CH_UNDERSCORE : CH_DOLLAR);
					default: push_char(pick_letter());
				endcase
			end
		end else if (k < 25) begin
			n = $urandom_range(1, 4);
			repeat (n) push_char(pick_digit());
		end else if (k < 37) begin
			n = $urandom_range(1, 3);
			repeat (n) push_char(pick_blank());
		end else if (k < 47) begin
			push_char(CH_NEWLINE);
		end else if (k < 55) begin
			push_char(CH_QUOTE);
			n = $urandom_range(0, 4);
			repeat (n) begin
				case ($urandom_range(0, 5))
					0: begin
						push_char(CH_QUOTE);
						push_char(CH_QUOTE);
					end
					1: push_char(CH_NEWLINE);
					default: begin
						c = CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
						push_char(c == CH_QUOTE ? CH_SPACE : c);
					end
				endcase
			end
			push_char(CH_QUOTE);
		end else if (k < 63) begin
			push_char(CH_BANG);
			n = $urandom_range(0, 6);
			repeat (n) begin
				c = CHAR_W'($urandom_range(0, 255));
				push_char(c == CH_NEWLINE ? CH_SPACE : c);
			end
			push_char(CH_NEWLINE);
		end else if (k < 72) begin
			push_char(CH_PERCENT);
			push_char(CH_LPAREN);
			n = $urandom_range(0, 6);
			repeat (n) begin
				case ($urandom_range(0, 6))
					0: push_char(CH_RPAREN);
					1: push_char(CH_NEWLINE);
					2: push_char(CH_PERCENT);
					3: push_char(CH_BANG);
					4: push_char(CH_QUOTE);
					5: push_char(CH_SPACE);
					default: push_char(pick_letter());
				endcase
			end
			push_char(CH_RPAREN);
			push_char(CH_PERCENT);
		end else if (k < 78) begin
			push_char(CH_PERCENT);
			case ($urandom_range(0, 2))
				0: push_char(pick_digit());
				1: push_char(CH_SPACE);
				default: push_char(pick_letter());
			endcase
		end else if (k < 86) begin
			push_char(CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
		end else if (k < 97) begin
			push_char(CHAR_W'($urandom_range(0, 255)));
		end else if (k < 98) begin
			// Broken fragments: a lone percent, a lone quote or an unclosed comment.
			case ($urandom_range(0, 2))
				0: push_char(CH_PERCENT);
				1: push_char(CH_QUOTE);
				default: begin
					push_char(CH_PERCENT);
					push_char(CH_LPAREN);
				end
			endcase
		end else begin
			w = '0;
			w.ch  = CHAR_W'($urandom_range(0, 255));
			w.eof = 1'b1;
			src_words.push_back(w);
		end
	endtask

	// Predictor and result checker, both sampled at the rising edge.
	line_t     pred_line;
	line_t     want_line;
	bit        pred_hit;
	src_word_t taken_word;

	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_chan.valid && byte_chan.ready) begin
				taken_word = src_words[accepted_n];
				accepted_n++;
				pred_hit = 1'b0;
				if (taken_word.eof)
					reset_scanner();
				else
					classify_byte(taken_word.ch, pred_hit, pred_line);
				if (taken_word.typed) begin
					want_line.cls = taken_word.cls;
					want_line.num = taken_word.num;
					pending_lines.push_back(want_line);
				end else if (pred_hit) begin
					pending_lines.push_back(pred_line);
				end
			end
			if (line_chan.valid && line_chan.ready) begin
				if (pending_lines.size() == 0) begin
					report_mismatch($sformatf("unexpected line class %0d number %0d",
						line_chan.line_class, line_chan.line_number));
				end else begin
					want_line = pending_lines.pop_front();
					if (line_chan.line_class !== want_line.cls)
						report_mismatch($sformatf("line %0d: class %0d, expected %0d",
							want_line.num, line_chan.line_class, want_line.cls));
					if (line_chan.line_number !== want_line.num)
						report_mismatch($sformatf("line number %0d, expected %0d",
							line_chan.line_number, want_line.num));
				end
			end
		end
	end

	// Receiver: random stalls, one long hold-off and one calm stretch.
	initial begin : sink_side
		int unsigned rx_cycle;
		rx_cycle = 0;
		line_chan.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle >= HOLD_FROM && rx_cycle < HOLD_FROM + HOLD_LEN)
				line_chan.ready <= 1'b0;
			else if (rx_cycle >= RX_CALM_FROM && rx_cycle < RX_CALM_FROM + RX_CALM_LEN)
				line_chan.ready <= 1'b1;
			else
				line_chan.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Overall time limit.
	initial begin
		#(TIMEOUT_NS);
		$display("FAIL bliss_source_line_classifier");
		$finish;
	end

	// Reset, stimulus, drain and verdict.
	initial begin : source_side
		int idx;
		src_word_t w;
		accepted_n = 0;
		mismatch_n = 0;
		reset_scanner();
		arst_n <= 1'b0;
		byte_chan.valid       <= 1'b0;
		byte_chan.char_code   <= '0;
		byte_chan.end_of_file <= 1'b0;

		for (idx = 0; idx < DIRECTED_N; idx++)
			src_words.push_back(DIRECTED_WORDS[idx]);
		while (src_words.size() < DIRECTED_N + RANDOM_N)
			add_fragment();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Offer each word in turn, idling at random outside the calm stretch.
		for (idx = 0; idx < src_words.size(); idx++) begin
			w = src_words[idx];
			while ((idx < TX_CALM_FROM || idx >= TX_CALM_TO) &&
					$urandom_range(0, 99) < IDLE_PCT) begin
				byte_chan.valid <= 1'b0;
				@(posedge clk);
			end
			byte_chan.valid       <= 1'b1;
			byte_chan.char_code   <= w.ch;
			byte_chan.end_of_file <= w.eof;
			@(posedge clk);
			while (!byte_chan.ready) @(posedge clk);
		end
		byte_chan.valid <= 1'b0;

		// Let the last word reach the predictor, then wait for every line.
		@(posedge clk);
		while (pending_lines.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_n == 0 && pending_lines.size() == 0) begin
			$display("PASS bliss_source_line_classifier");
		end else begin
			$display("FAIL bliss_source_line_classifier");
		end
		$finish;
	end

endmodule

@@ bliss_source_line_classifier.f @@
sv/bslc_pkg.sv
sv/bslc_in_if.sv
sv/bslc_out_if.sv
sv/bslc_scan.sv
sv/bslc_line_count.sv
sv/bliss_source_line_classifier.sv
tb/sv/tb_top.sv
